// ----- rtl/core/u8u16_pkg.sv -----
// Shared types and constants for the UTF-8 to UTF-16 descriptor transcoder.
package u8u16_pkg;

  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = $clog2(QDepth);

  localparam logic [1:0] CAUSE_NONE = 2'd0;
  localparam logic [1:0] CAUSE_NUL  = 2'd1;
  localparam logic [1:0] CAUSE_BAD  = 2'd2;

  localparam logic [7:0]  LEN_INIT    = 8'd2;
  localparam logic [7:0]  HDR_TYPE    = 8'h03;
  localparam logic [15:0] HI_SURR     = 16'hD800;
  localparam logic [15:0] LO_SURR     = 16'hDC00;
  localparam logic [20:0] SUPP_BASE   = 21'h10000;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       string_start;
  } in_t;

  typedef struct packed {
    logic [15:0] code_unit;
    logic        kind;
    logic [1:0]  stop_cause;
    logic        last;
  } out_t;

  typedef enum logic [1:0] {
    OP_UNIT,
    OP_PAIR,
    OP_HDR
  } op_kind_t;

  // One decoded operation: a BMP unit, a supplementary code point (minus
  // 0x10000) to split into a surrogate pair, or the closing header.
  typedef struct packed {
    op_kind_t    kind;
    logic [19:0] value;
    logic [1:0]  cause;
  } op_t;

endpackage

// ----- rtl/core/utf8_to_utf16_string_descriptor.sv -----
// Top level: UTF-8 string in, UTF-16 descriptor units and header word out.
// Path: a result passes through the op queue, then the output register.
// Throughput: one byte per cycle in while the queue has room; one beat per cycle
//   out while popped; a surrogate pair is two beats, the 4-entry queue absorbs it.
// Reset: synchronous, active low; clears the queue and output register and
//   leaves the decoder finished, waiting for a beat with string_start set.
module utf8_to_utf16_string_descriptor (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_push,
  output logic            in_full,
  input  u8u16_pkg::in_t  in_data,
  output logic            out_empty,
  input  logic            out_pop,
  output u8u16_pkg::out_t out_data
);
  import u8u16_pkg::*;

  logic in_accept;
  logic op_valid;
  op_t  op;
  op_t  head;
  logic q_full, q_empty, q_pop;

  // Take a byte whenever the op queue has room; every byte yields at most one op.
  assign in_accept = in_push && !in_full;
  assign in_full   = q_full;

  // Decode: track the UTF-8 sequence and the running descriptor length.
  u8u16_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (in_accept),
    .in_data  (in_data),
    .op_valid (op_valid),
    .op       (op)
  );

  // Queue decoded ops so the emitter can stall independently.
  u8u16_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (in_accept && op_valid),
    .wr_data (op),
    .full    (q_full),
    .rd_en   (q_pop),
    .rd_data (head),
    .empty   (q_empty)
  );

  // Emit: one beat per cycle while popped, split supplementary code points into pairs.
  u8u16_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data)
  );

endmodule

// ----- rtl/core/u8u16_front.sv -----
// Front end: UTF-8 decoder that turns each accepted byte into at most one op.
module u8u16_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             accept,
  input  u8u16_pkg::in_t   in_data,
  output logic             op_valid,
  output u8u16_pkg::op_t   op
);
  import u8u16_pkg::*;

  logic [20:0] acc_r, acc_nxt;
  logic [1:0]  rem_r, rem_nxt;
  logic [1:0]  seq_r, seq_nxt;
  logic [7:0]  len_r, len_nxt;
  logic        fin_r, fin_nxt;

  logic [20:0] acc_s, cp;
  logic [1:0]  rem_s, seq_s, rem_dec;
  logic [7:0]  len_s, b;
  logic        fin_s, bad_cp;
  logic [8:0]  len_sum;

  always_comb begin
    b = in_data.byte_value;
    // string start clears the decoder before the byte is taken
    acc_s = in_data.string_start ? 21'd0 : acc_r;
    rem_s = in_data.string_start ? 2'd0 : rem_r;
    seq_s = in_data.string_start ? 2'd0 : seq_r;
    len_s = in_data.string_start ? LEN_INIT : len_r;
    fin_s = in_data.string_start ? 1'b0 : fin_r;

    acc_nxt = acc_s;
    rem_nxt = rem_s;
    seq_nxt = seq_s;
    len_nxt = len_s;
    fin_nxt = fin_s;
    op_valid = 1'b0;
    op.kind  = OP_HDR;
    op.value = {12'd0, len_s};
    op.cause = CAUSE_BAD;

    cp      = {acc_s[14:0], b[5:0]};
    rem_dec = rem_s - 2'd1;
    len_sum = {1'b0, len_s} + 9'd2;

    case (seq_s)
      2'd1:    bad_cp = (cp < 21'h80) || (cp > 21'h7FF);
      2'd2:    bad_cp = (cp < 21'h800) || (cp > 21'hFFFF);
      default: bad_cp = (cp < 21'h10000) || (cp > 21'h10FFFF);
    endcase
    bad_cp = bad_cp || ((cp >= 21'hD800) && (cp <= 21'hDFFF));

    if (!fin_s) begin
      if (rem_s == 2'd0) begin
        if (b == 8'd0) begin
          op_valid = 1'b1;
          op.cause = CAUSE_NUL;
          fin_nxt  = 1'b1;
        end else if (b <= 8'h7F) begin
          op_valid = 1'b1;
          op.kind  = OP_UNIT;
          op.value = {12'd0, b};
          op.cause = CAUSE_NONE;
        end else if (b <= 8'hC1) begin
          op_valid = 1'b1;
          fin_nxt  = 1'b1;
        end else if (b <= 8'hDF) begin
          acc_nxt = {16'd0, b[4:0]};
          rem_nxt = 2'd1;
          seq_nxt = 2'd1;
        end else if (b <= 8'hEF) begin
          acc_nxt = {17'd0, b[3:0]};
          rem_nxt = 2'd2;
          seq_nxt = 2'd2;
        end else if (b <= 8'hF4) begin
          acc_nxt = {18'd0, b[2:0]};
          rem_nxt = 2'd3;
          seq_nxt = 2'd3;
        end else begin
          op_valid = 1'b1;
          fin_nxt  = 1'b1;
        end
      end else if (b[7:6] != 2'b10) begin
        op_valid = 1'b1;
        fin_nxt  = 1'b1;
      end else if (rem_dec != 2'd0) begin
        acc_nxt = cp;
        rem_nxt = rem_dec;
      end else if (bad_cp) begin
        op_valid = 1'b1;
        fin_nxt  = 1'b1;
      end else begin
        op_valid = 1'b1;
        op.cause = CAUSE_NONE;
        acc_nxt  = 21'd0;
        rem_nxt  = 2'd0;
        seq_nxt  = 2'd0;
        if (cp[20:16] == 5'd0) begin
          op.kind  = OP_UNIT;
          op.value = {4'd0, cp[15:0]};
        end else begin
          op.kind  = OP_PAIR;
          op.value = cp[19:0] - SUPP_BASE[19:0];
          len_sum  = {1'b0, len_s} + 9'd4;
        end
      end
    end

    if (op_valid && op.kind != OP_HDR) begin
      len_nxt = len_sum[8] ? 8'hFF : len_sum[7:0];
    end
    if (fin_nxt && !fin_s) begin
      acc_nxt = 21'd0;
      rem_nxt = 2'd0;
      seq_nxt = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= 21'd0;
      rem_r <= 2'd0;
      seq_r <= 2'd0;
      len_r <= LEN_INIT;
      fin_r <= 1'b1;
    end else if (accept) begin
      acc_r <= acc_nxt;
      rem_r <= rem_nxt;
      seq_r <= seq_nxt;
      len_r <= len_nxt;
      fin_r <= fin_nxt;
    end
  end

endmodule

// ----- rtl/core/u8u16_fifo.sv -----
// Short op queue between the decoder and the unit emitter.
module u8u16_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            wr_en,
  input  u8u16_pkg::op_t  wr_data,
  output logic            full,
  input  logic            rd_en,
  output u8u16_pkg::op_t  rd_data,
  output logic            empty
);
  import u8u16_pkg::*;

  op_t              mem_r [QDepth];
  logic [QPtrW-1:0] wr_ptr_r, rd_ptr_r;
  logic [QPtrW:0]   cnt_r, cnt_nxt;

  assign full    = (cnt_r == QDepth[QPtrW:0]);
  assign empty   = (cnt_r == '0);
  assign rd_data = mem_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (wr_en && !rd_en) cnt_nxt = cnt_r + 1'b1;
    if (rd_en && !wr_en) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem_r[wr_ptr_r] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (wr_en) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (rd_en) rd_ptr_r <= rd_ptr_r + 1'b1;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// ----- rtl/core/u8u16_back.sv -----
// Back end: expands queued ops into UTF-16 beats held in an output register.
module u8u16_back (
  input  logic            clk,
  input  logic            rst_n,
  input  u8u16_pkg::op_t  head,
  input  logic            q_empty,
  output logic            q_pop,
  output logic            out_empty,
  input  logic            out_pop,
  output u8u16_pkg::out_t out_data
);
  import u8u16_pkg::*;

  logic valid_r, valid_nxt;
  logic half_r, half_nxt;
  out_t data_r, beat;
  logic load, take, first_half;

  always_comb begin
    load       = !valid_r || out_pop;
    take       = load && !q_empty;
    first_half = (head.kind == OP_PAIR) && !half_r;

    beat.kind       = 1'b0;
    beat.stop_cause = CAUSE_NONE;
    beat.last       = 1'b0;
    case (head.kind)
      OP_UNIT: beat.code_unit = head.value[15:0];
      OP_PAIR: beat.code_unit = half_r ? (LO_SURR + {6'd0, head.value[9:0]})
                                       : (HI_SURR + {6'd0, head.value[19:10]});
      OP_HDR: begin
        beat.code_unit  = {HDR_TYPE, head.value[7:0]};
        beat.kind       = 1'b1;
        beat.stop_cause = head.cause;
        beat.last       = 1'b1;
      end
      default: beat.code_unit = head.value[15:0];
    endcase

    // hold a pair op in the queue until its low half is loaded into the output register
    q_pop     = take && !first_half;
    half_nxt  = take ? first_half : half_r;
    valid_nxt = load ? !q_empty : valid_r;
  end

  assign out_empty = !valid_r;
  assign out_data  = data_r;

  always_ff @(posedge clk) begin
    if (take) data_r <= beat;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      half_r  <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      half_r  <= half_nxt;
    end
  end

endmodule

// ----- rtl/core/u8u16_checker.sv -----
// Port-level checks for the transcoder, bound to the top level.
module u8u16_checker (
  input logic            clk,
  input logic            rst_n,
  input logic            out_empty,
  input logic            out_pop,
  input u8u16_pkg::out_t out_data
);
  import u8u16_pkg::*;

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> out_empty)
    else $error("output not empty after reset");

  a_hdr_form: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_data.kind) |->
      (out_data.last && out_data.code_unit[15:8] == HDR_TYPE &&
       (out_data.stop_cause == CAUSE_NUL || out_data.stop_cause == CAUSE_BAD)))
    else $error("malformed header beat");

  a_data_form: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_data.kind) |->
      (!out_data.last && out_data.stop_cause == CAUSE_NONE))
    else $error("data beat carries end marking");

  a_pair_follow: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_pop && !out_data.kind &&
     out_data.code_unit[15:10] == 6'b110110) |=>
      (!out_empty && !out_data.kind && out_data.code_unit[15:10] == 6'b110111))
    else $error("high surrogate not followed by low surrogate");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> (!out_empty && $stable(out_data)))
    else $error("stalled beat changed");

endmodule

bind utf8_to_utf16_string_descriptor u8u16_checker u_chk (.*);

// ----- tb/sv/utf16_descriptor_check_pkg.sv -----
// Scoreboard class: predicts UTF-16 descriptor beats and checks the block's results.
package utf16_descriptor_check_pkg;
  import u8u16_pkg::*;

  class utf16_descriptor_tracker;
    logic [20:0] code_acc;
    logic [1:0]  cont_left;
    logic [1:0]  seq_cont;
    logic [7:0]  desc_len;
    logic        idle;
    out_t        units_due[$];
    int unsigned fault_count;

    function new();
      code_acc    = '0;
      cont_left   = '0;
      seq_cont    = '0;
      desc_len    = LEN_INIT;
      idle        = 1'b1;
      fault_count = 0;
    endfunction

    function void emit(logic [15:0] unit, logic hdr, logic [1:0] cause);
      out_t u;
      u.code_unit  = unit;
      u.kind       = hdr;
      u.stop_cause = cause;
      u.last       = hdr;
      units_due.push_back(u);
    endfunction

    function void grow_length(int unsigned n);
      int unsigned sum;
      sum = desc_len + n;
      desc_len = (sum > 255) ? 8'd255 : 8'(sum);
    endfunction

    function void close_string(logic [1:0] cause);
      emit({HDR_TYPE, desc_len}, 1'b1, cause);
      idle      = 1'b1;
      cont_left = '0;
      seq_cont  = '0;
      code_acc  = '0;
    endfunction

    // Advance the decoder by one accepted input beat and queue what it yields.
    function void note_byte(in_t beat);
      logic [7:0]  b;
      int unsigned cp;
      bit          bad;
      b = beat.byte_value;
      if (beat.string_start) begin
        code_acc  = '0;
        cont_left = '0;
        seq_cont  = '0;
        desc_len  = LEN_INIT;
        idle      = 1'b0;
      end
      if (idle) return;

      if (cont_left == 2'd0) begin
        if (b == 8'h00) close_string(CAUSE_NUL);
        else if (b <= 8'h7F) begin
          emit({8'h00, b}, 1'b0, CAUSE_NONE);
          grow_length(2);
        end else if (b <= 8'hC1) close_string(CAUSE_BAD);
        else if (b <= 8'hDF) begin
          code_acc  = 21'(b[4:0]);
          cont_left = 2'd1;
          seq_cont  = 2'd1;
        end else if (b <= 8'hEF) begin
          code_acc  = 21'(b[3:0]);
          cont_left = 2'd2;
          seq_cont  = 2'd2;
        end else if (b <= 8'hF4) begin
          code_acc  = 21'(b[2:0]);
          cont_left = 2'd3;
          seq_cont  = 2'd3;
        end else close_string(CAUSE_BAD);
        return;
      end

      if (b < 8'h80 || b > 8'hBF) begin
        close_string(CAUSE_BAD);
        return;
      end
      code_acc  = {code_acc[14:0], b[5:0]};
      cont_left = cont_left - 2'd1;
      if (cont_left != 2'd0) return;

      cp = {11'd0, code_acc};
      case (seq_cont)
        2'd1:    bad = (cp < 'h80) || (cp > 'h7FF);
        2'd2:    bad = (cp < 'h800) || (cp > 'hFFFF);
        default: bad = (cp < 'h10000) || (cp > 'h10FFFF);
      endcase
      if (cp >= 'hD800 && cp <= 'hDFFF) bad = 1'b1;
      if (bad) begin
        close_string(CAUSE_BAD);
        return;
      end

      code_acc = '0;
      seq_cont = '0;
      if (cp <= 'hFFFF) begin
        emit(16'(cp), 1'b0, CAUSE_NONE);
        grow_length(2);
      end else begin
        cp = cp - 'h10000;
        emit(HI_SURR + 16'(cp >> 10), 1'b0, CAUSE_NONE);
        emit(LO_SURR + 16'(cp & 'h3FF), 1'b0, CAUSE_NONE);
        grow_length(4);
      end
    endfunction

    // Count a fault; report only the first ten.
    function bit tally_fault();
      fault_count++;
      return fault_count <= 10;
    endfunction

    function void check_unit(out_t got);
      out_t want;
      if (units_due.size() == 0) begin
        if (tally_fault())
          $display("unexpected result beat: unit %h kind %0d cause %0d last %0d",
                   got.code_unit, got.kind, got.stop_cause, got.last);
        return;
      end
      want = units_due.pop_front();
      if (got.code_unit !== want.code_unit || got.kind !== want.kind ||
          got.stop_cause !== want.stop_cause || got.last !== want.last) begin
        if (tally_fault())
          $display("result mismatch (exp/got): unit %h/%h kind %0d/%0d cause %0d/%0d last %0d/%0d",
                   want.code_unit, got.code_unit, want.kind, got.kind,
                   want.stop_cause, got.stop_cause, want.last, got.last);
      end
    endfunction

    function int unsigned pending();
      return units_due.size();
    endfunction
  endclass

endpackage

// ----- tb/sv/tb_utf8_to_utf16_string_descriptor.sv -----
// Testbench top: feeds UTF-8 strings into the transcoder and checks every UTF-16 beat.
module tb_utf8_to_utf16_string_descriptor;
  import u8u16_pkg::*;
  import utf16_descriptor_check_pkg::*;

  // Every block input is known from time zero.
  logic clk     = 1'b0;
  logic rst_n   = 1'b0;
  logic in_push = 1'b0;
  in_t  in_data = '0;
  logic out_pop = 1'b0;
  logic in_full;
  logic out_empty;
  out_t out_data;

  utf16_descriptor_tracker tracker;

  // Idle-free stretches on each side, redrawn now and then.
  bit in_calm  = 1'b0;
  bit out_calm = 1'b0;

  // Bytes of the string being built, first byte carries string_start.
  logic [7:0]  string_bytes[$];
  int unsigned bytes_fed = 0;

  always #1 clk = ~clk;

  utf8_to_utf16_string_descriptor i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_data   (in_data),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data)
  );

  // Push one byte: idle for a random gap, then hold push until the block takes it.
  // Called at a rising edge; each time step sees at most one assignment to in_push.
  task automatic send_byte(logic [7:0] b, logic first);
    in_t         beat;
    int unsigned gap;
    beat.byte_value   = b;
    beat.string_start = first;
    gap = in_calm ? 0 : $urandom_range(0, 5);
    repeat (gap) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
    in_push <= 1'b1;
    in_data <= beat;
    // Values read right after the edge are the ones the block saw at that edge.
    do @(posedge clk); while (in_full);
    tracker.note_byte(beat);
  endtask

  // Send the staged string; only its first byte starts a new string.
  task automatic send_string();
    int unsigned k;
    for (k = 0; k < string_bytes.size(); k++)
      send_byte(string_bytes[k], k == 0);
    bytes_fed += string_bytes.size();
    string_bytes.delete();
  endtask

  // Encode a value with a forced byte count, so overlong and out-of-range forms
  // come out of the same path as legal ones.
  function automatic void append_encoded(int unsigned cp, int unsigned n);
    case (n)
      1: string_bytes.push_back(8'(cp));
      2: begin
        string_bytes.push_back({3'b110, cp[10:6]});
        string_bytes.push_back({2'b10, cp[5:0]});
      end
      3: begin
        string_bytes.push_back({4'b1110, cp[15:12]});
        string_bytes.push_back({2'b10, cp[11:6]});
        string_bytes.push_back({2'b10, cp[5:0]});
      end
      default: begin
        string_bytes.push_back({5'b11110, cp[20:18]});
        string_bytes.push_back({2'b10, cp[17:12]});
        string_bytes.push_back({2'b10, cp[11:6]});
        string_bytes.push_back({2'b10, cp[5:0]});
      end
    endcase
  endfunction

  // Append one legal code point; long strings lean on ASCII to reach saturation.
  function automatic void append_valid(bit mostly_ascii);
    int unsigned cls;
    int unsigned cp;
    if (!mostly_ascii && $urandom_range(0, 7) == 0) begin
      // Range boundaries of each encoding length and around the surrogate hole.
      case ($urandom_range(0, 7))
        0:       cp = 'h80;
        1:       cp = 'h7FF;
        2:       cp = 'h800;
        3:       cp = 'hFFFF;
        4:       cp = 'hD7FF;
        5:       cp = 'hE000;
        6:       cp = 'h10000;
        default: cp = 'h10FFFF;
      endcase
    end else begin
      if (mostly_ascii)
        cls = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 3) : 0;
      else
        cls = $urandom_range(0, 3);
      case (cls)
        0: cp = $urandom_range(1, 'h7F);
        1: cp = $urandom_range('h80, 'h7FF);
        2: begin
          cp = $urandom_range('h800, 'hFFFF);
          // Move surrogates out of the hole.
          if (cp >= 'hD800 && cp <= 'hDFFF) cp = cp ^ 'h1000;
        end
        default: cp = $urandom_range('h10000, 'h10FFFF);
      endcase
    end
    append_encoded(cp, (cp < 'h80) ? 1 : (cp < 'h800) ? 2 : (cp < 'h10000) ? 3 : 4);
  endfunction

  // Append one flaw: a raw byte, an overlong form, a surrogate, a value above
  // the Unicode range, or a multi-byte sequence cut short.
  function automatic void append_defect();
    int unsigned n;
    int unsigned cp;
    int unsigned cut;
    case ($urandom_range(0, 4))
      0: string_bytes.push_back(8'($urandom_range(0, 255)));
      1: begin
        n  = $urandom_range(2, 4);
        cp = $urandom_range(0, (n == 2) ? 'h7F : (n == 3) ? 'h7FF : 'hFFFF);
        append_encoded(cp, n);
      end
      2: append_encoded($urandom_range('hD800, 'hDFFF), 3);
      3: append_encoded($urandom_range('h110000, 'h1FFFFF), 4);
      default: begin
        n  = $urandom_range(2, 4);
        cp = (n == 2) ? $urandom_range('h80, 'h7FF) :
             (n == 3) ? $urandom_range('h800, 'hD7FF) : $urandom_range('h10000, 'h10FFFF);
        append_encoded(cp, n);
        cut = $urandom_range(1, n - 1);
        repeat (cut) void'(string_bytes.pop_back());
      end
    endcase
  endfunction

  // Build a string of legal code points, now and then with one flaw, usually
  // closed by NUL; an open string is cut off by the next string start.
  // Return whether it ends with NUL.
  function automatic bit build_random_string(bit long_one);
    int unsigned count;
    int unsigned flaw_at;
    int unsigned k;
    bit          flawed;
    bit          closed;
    count   = long_one ? $urandom_range(128, 140) : $urandom_range(0, 8);
    flawed  = ($urandom_range(0, 4) == 0);
    flaw_at = $urandom_range(0, count);
    for (k = 0; k <= count; k++) begin
      if (flawed && k == flaw_at) append_defect();
      if (k < count) append_valid(long_one);
    end
    closed = ($urandom_range(0, 7) != 0) || (string_bytes.size() == 0);
    if (closed) string_bytes.push_back(8'h00);
    return closed;
  endfunction

  // Result side: stall a random number of cycles per beat, then pop and check.
  initial begin
    int unsigned stall;
    int unsigned beats;
    beats = 0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (beats % 24 == 0) out_calm = ($urandom_range(0, 3) == 0);
      stall = out_calm ? 0 : $urandom_range(0, 5);
      repeat (stall) begin
        out_pop <= 1'b0;
        @(posedge clk);
      end
      out_pop <= 1'b1;
      do @(posedge clk); while (out_empty);
      tracker.check_unit(out_data);
      beats++;
    end
  end

  // Stimulus and end of run.
  initial begin
    int unsigned spin;
    int unsigned n;
    bit          closed;
    bit          first_long;
    tracker = new();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part. Out of reset the decoder is finished: drop a plain byte.
    send_byte(8'h41, 1'b0);
    // Top of ASCII, top of each multi-byte length (U+07FF, U+FFFF, U+10FFFF), NUL.
    string_bytes = '{8'h7F, 8'hDF, 8'hBF, 8'hEF, 8'hBF, 8'hBF,
                     8'hF4, 8'h8F, 8'hBF, 8'hBF, 8'h00};
    send_string();
    // Open a 2-byte sequence, then restart mid-sequence.
    string_bytes = '{8'hC2};
    send_string();
    // Lowest supplementary point, then NUL where a continuation belongs.
    string_bytes = '{8'hF0, 8'h90, 8'h80, 8'h80, 8'hC2, 8'h00};
    send_string();
    // Bad lead bytes at both ends, and an encoded surrogate.
    string_bytes = '{8'hC1};
    send_string();
    string_bytes = '{8'hED, 8'hA0, 8'h80};
    send_string();
    string_bytes = '{8'hF5};
    send_string();

    // Random part: mostly well-formed strings with random content.
    bytes_fed  = 0;
    first_long = 1'b1;
    while (bytes_fed < 650) begin
      in_calm = ($urandom_range(0, 3) == 0);
      closed  = build_random_string(first_long || ($urandom_range(0, 15) == 0));
      first_long = 1'b0;
      send_string();
      // Bytes after a finished string are ignored; keep them out of the count.
      if (closed && $urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, 3);
        repeat (n) send_byte(8'($urandom_range(0, 255)), 1'b0);
      end
    end
    in_push <= 1'b0;

    // Drain: wait for every predicted beat, then keep watching for strays.
    spin = 0;
    while (tracker.pending() != 0 && spin < 5000) begin
      @(posedge clk);
      spin++;
    end
    repeat (8) @(posedge clk);

    if (tracker.pending() != 0)
      $display("%0d predicted beats never arrived", tracker.pending());
    if (tracker.fault_count == 0 && tracker.pending() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Hang guard, far beyond the slowest legal run.
  initial begin
    #2000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

// ----- utf8_to_utf16_string_descriptor.f -----
rtl/core/u8u16_pkg.sv
rtl/core/u8u16_front.sv
rtl/core/u8u16_fifo.sv
rtl/core/u8u16_back.sv
rtl/core/utf8_to_utf16_string_descriptor.sv
rtl/core/u8u16_checker.sv
tb/sv/utf16_descriptor_check_pkg.sv
tb/sv/tb_utf8_to_utf16_string_descriptor.sv
